>>> rtl/core/lrb_pkg.sv
// Shared widths, operation and status codes, and the controller command struct
// for the log ring buffer. No dependencies.
package lrb_pkg;

  localparam int BUF_BYTES_DEF = 1024;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 12;
  localparam int STAT_W = 2;
  localparam int FILL_W = 11;
  localparam int OVR_W  = 16;

  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OP_W-1:0] OP_OPEN  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERRUN  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic [OVR_W-1:0] OVR_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the accepted item
    logic exec;     // update state, access the byte store
    logic publish;  // load the output registers
  } dp_cmd_t;

endpackage

>>> rtl/core/lrb_in_if.sv
// Input channel of the log ring buffer: valid/ready plus one operation item.
// Depends on lrb_pkg.
interface lrb_in_if import lrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_in;
  logic [LEN_W-1:0]  msg_len;

  modport source (output valid, output operation, output data_in, output msg_len,
                  input ready);
  modport sink   (input valid, input operation, input data_in, input msg_len,
                  output ready);
endinterface

>>> rtl/core/lrb_out_if.sv
// Result channel of the log ring buffer: valid/ready plus one result item.
// Depends on lrb_pkg.
interface lrb_out_if import lrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] data_out;
  logic [FILL_W-1:0] fill_count;
  logic [OVR_W-1:0]  overrun_total;

  modport source (output valid, output status, output data_out, output fill_count,
                  output overrun_total, input ready);
  modport sink   (input valid, input status, input data_out, input fill_count,
                  input overrun_total, output ready);
endinterface

>>> rtl/core/lrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/lrb_datapath.sv
// Datapath of the log ring buffer: item registers, positions, occupancy,
// overrun counter, byte store and result registers. Depends on lrb_pkg, lrb_ram.
module lrb_datapath import lrb_pkg::*; #(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [BYTE_W-1:0] in_data,
  input  logic [LEN_W-1:0]  in_len,
  output logic [STAT_W-1:0] out_status,
  output logic [BYTE_W-1:0] out_data,
  output logic [FILL_W-1:0] out_fill,
  output logic [OVR_W-1:0]  out_overrun
);

  localparam int PW = $clog2(BUF_BYTES);
  localparam int OW = $clog2(BUF_BYTES + 1);
  localparam int CW = ((LEN_W > OW) ? LEN_W : OW) + 1;
  localparam logic [PW-1:0] LAST_POS = PW'(BUF_BYTES - 1);
  localparam logic [CW-1:0] CAP      = CW'(BUF_BYTES);
  localparam logic [OW-1:0] OCC_FULL = OW'(BUF_BYTES);

  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] byte_r;
  logic [LEN_W-1:0]  len_r;

  logic [PW-1:0]     wr_pos_r, wr_pos_nxt;
  logic [PW-1:0]     rd_pos_r, rd_pos_nxt;
  logic [OW-1:0]     occ_r, occ_nxt;
  logic [OVR_W-1:0]  ovr_r, ovr_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic              res_rd_r, res_rd_nxt;

  logic [STAT_W-1:0] o_status_r;
  logic [BYTE_W-1:0] o_data_r;
  logic [FILL_W-1:0] o_fill_r;
  logic [OVR_W-1:0]  o_ovr_r;

  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              full;
  logic [PW-1:0]     wr_base;
  logic [CW-1:0]     free_space;
  logic [OVR_W-1:0]  ovr_bumped;

  assign full       = (occ_r == OCC_FULL);
  assign wr_base    = full ? rd_pos_r : wr_pos_r;
  assign free_space = CAP - CW'(occ_r);
  assign ovr_bumped = (ovr_r != OVR_MAX) ? ovr_r + 1'b1 : ovr_r;

  always_comb begin
    wr_pos_nxt     = wr_pos_r;
    rd_pos_nxt     = rd_pos_r;
    occ_nxt        = occ_r;
    ovr_nxt        = ovr_r;
    res_status_nxt = ST_OK;
    res_rd_nxt     = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = wr_base;
    case (op_r)
      OP_START: begin
        if (CW'(len_r) > CAP) begin
          res_status_nxt = ST_TOO_LONG;
        end else if (CW'(len_r) > free_space) begin
          wr_pos_nxt     = rd_pos_r;
          occ_nxt        = '0;
          ovr_nxt        = ovr_bumped;
          res_status_nxt = ST_OVERRUN;
        end
      end
      OP_WRITE: begin
        // A full buffer flushes first, then the byte lands at the read position.
        ram_we     = 1'b1;
        wr_pos_nxt = (wr_base == LAST_POS) ? '0 : wr_base + 1'b1;
        if (full) begin
          occ_nxt        = OW'(1);
          ovr_nxt        = ovr_bumped;
          res_status_nxt = ST_OVERRUN;
        end else begin
          occ_nxt = occ_r + 1'b1;
        end
      end
      OP_READ: begin
        if (occ_r == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          ram_re     = 1'b1;
          res_rd_nxt = 1'b1;
          rd_pos_nxt = (rd_pos_r == LAST_POS) ? '0 : rd_pos_r + 1'b1;
          occ_nxt    = occ_r - 1'b1;
        end
      end
      OP_OPEN: begin
        ovr_nxt = '0;
      end
      default: begin
      end
    endcase
    if (!cmd.exec) begin
      ram_we = 1'b0;
      ram_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r     <= '0;
      rd_pos_r     <= '0;
      occ_r        <= '0;
      ovr_r        <= '0;
      res_status_r <= ST_OK;
      res_rd_r     <= 1'b0;
    end else if (cmd.exec) begin
      wr_pos_r     <= wr_pos_nxt;
      rd_pos_r     <= rd_pos_nxt;
      occ_r        <= occ_nxt;
      ovr_r        <= ovr_nxt;
      res_status_r <= res_status_nxt;
      res_rd_r     <= res_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_operation;
      byte_r <= in_data;
      len_r  <= in_len;
    end
    if (cmd.publish) begin
      o_status_r <= res_status_r;
      o_data_r   <= res_rd_r ? ram_rdata : '0;
      o_fill_r   <= FILL_W'(occ_r);
      o_ovr_r    <= ovr_r;
    end
  end

  lrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_BYTES),
    .AW    (PW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (rd_pos_r),
    .rdata (ram_rdata)
  );

  assign out_status  = o_status_r;
  assign out_data    = o_data_r;
  assign out_fill    = o_fill_r;
  assign out_overrun = o_ovr_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("occupancy above capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> wr_pos_r == rd_pos_r)
    else $error("empty buffer with split positions");

  a_store_access: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we || ram_re) |-> cmd.exec && !(ram_we && ram_re))
    else $error("byte store accessed outside execute");

endmodule

>>> rtl/core/lrb_ctrl.sv
// Controller of the log ring buffer: sequences accept, execute and result
// hand-off. Depends on lrb_pkg.
module lrb_ctrl import lrb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The output register is free when empty or when its item leaves this cycle.
  assign slot_free   = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.latch   = in_valid && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.publish = (state_r == S_DONE) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == S_EXEC)
    else $error("accepted item not executed");

  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r && state_r == S_IDLE)
    else $error("published result not presented");

endmodule

>>> rtl/core/log_ring_buffer.sv
// Top level of the log ring buffer: controller plus datapath.
// Depends on lrb_pkg, lrb_in_if, lrb_out_if, lrb_ctrl, lrb_datapath.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid / ready  operation, data_in, msg_len
//   out_ch   out  valid / ready  status, data_out, fill_count, overrun_total
//
// Each item passes three steps: accept, execute, result load. The registered
// read port of the byte store sets the gap between execute and result load.
// A result waiting in the output register holds a finished item in the load
// step until out_ch takes it; no new item is accepted meanwhile.
// Synchronous active-low reset empties the buffer and clears the overrun count.
module log_ring_buffer import lrb_pkg::*; #(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  lrb_in_if.sink   in_ch,
  lrb_out_if.source out_ch
);

  dp_cmd_t cmd;

  lrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  lrb_datapath #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_ch.operation),
    .in_data      (in_ch.data_in),
    .in_len       (in_ch.msg_len),
    .out_status   (out_ch.status),
    .out_data     (out_ch.data_out),
    .out_fill     (out_ch.fill_count),
    .out_overrun  (out_ch.overrun_total)
  );

endmodule
